FILE: hdl/ppct_pkg.sv
package ppct_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_EVENT = 2'd1;
	localparam logic [1:0] REQ_SET   = 2'd2;

	localparam logic CFG_CYCLE_LENGTH = 1'b0;
	localparam logic CFG_REARM_COUNT  = 1'b1;

	localparam logic [15:0] RESET_CYCLE_LENGTH = 16'd25000;
	localparam logic [15:0] RESET_REARM_COUNT  = 16'd17000;
	localparam logic [15:0] INIT_COMPARE       = 16'd16000;
	localparam logic [7:0]  POT_MIN            = 8'd1;
	localparam logic [7:0]  POT_MAX            = 8'd228;
	localparam int unsigned POT_SCALE_SHIFT    = 6;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_EVENT,
		OP_SET,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        pot_index;
		logic [7:0]  pot_value;
		logic [31:0] timestamp_ms;
	} in_item_t;

	typedef struct packed {
		logic       charge_pot0;
		logic       charge_pot1;
		logic [7:0] period_ms;
		logic       comparator_armed;
		logic       event_ignored;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic        pot_index;
		logic [15:0] cmp_value;
		logic [31:0] timestamp_ms;
	} cmd_t;

	typedef struct packed {
		logic [15:0] cycle_length;
		logic [15:0] rearm_count;
	} cfg_t;

endpackage

FILE: hdl/ppct_front.sv
module ppct_front
	import ppct_pkg::*;
(
	input  logic     in_valid,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     in_stall,
	output logic     push,
	output cmd_t     cmd
);

	logic [7:0] pot_clamped;

	always_comb begin
		pot_clamped = in_data.pot_value;
		if (in_data.pot_value < POT_MIN) begin
			pot_clamped = POT_MIN;
		end else if (in_data.pot_value > POT_MAX) begin
			pot_clamped = POT_MAX;
		end
	end

	always_comb begin
		unique case (in_data.req_type)
			REQ_TICK: begin
				cmd.op = OP_TICK;
			end
			REQ_EVENT: begin
				cmd.op = OP_EVENT;
			end
			REQ_SET: begin
				cmd.op = OP_SET;
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
		cmd.pot_index    = in_data.pot_index;
		cmd.cmp_value    = 16'(pot_clamped) << POT_SCALE_SHIFT;
		cmd.timestamp_ms = in_data.timestamp_ms;
	end

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

endmodule

FILE: hdl/ppct_queue.sv
module ppct_queue
	import ppct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue transfer while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

FILE: hdl/ppct_back.sv
module ppct_back
	import ppct_pkg::*;
#(
	parameter int unsigned FILTER_DEPTH = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      head_valid,
	input  cmd_t      cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int unsigned POS_W       = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int unsigned SUM_W       = $clog2(FILTER_DEPTH * 255 + 1);
	localparam int unsigned DIV_L       = $clog2(FILTER_DEPTH);
	localparam int unsigned RECIP_SHIFT = SUM_W + DIV_L;
	localparam int unsigned RECIP_W     = SUM_W + 1;
	localparam int unsigned PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / FILTER_DEPTH + 64'd1);

	logic [15:0]       cnt_q, cnt_d;
	logic              armed_q, armed_d;
	logic [1:0]        pins_q, pins_d;
	logic [1:0][15:0]  act_q, act_d;
	logic [1:0][15:0]  pend_q, pend_d;
	logic              tvalid_q, tvalid_d;
	logic [31:0]       last_q, last_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [7:0]        ring_mem [FILTER_DEPTH];
	logic [FILTER_DEPTH-1:0] vld_q;
	logic [7:0]        rd_data_q;
	logic              rd_vld_q;
	logic              byp_q;
	logic [7:0]        byp_data_q;

	logic              exec;
	logic              ring_upd;
	logic              mem_we;
	logic              ignored;
	logic [15:0]       tick_cnt;
	logic [31:0]       ts_diff;
	logic [7:0]        diff;
	logic [7:0]        oldest;
	logic [POS_W-1:0]  pos_inc;
	logic [POS_W-1:0]  rd_addr;
	logic [PROD_W-1:0] prod;

	assign exec     = head_valid & (~out_valid_q | ~out_stall);
	assign pop      = exec;
	assign tick_cnt = cnt_q + 16'd1;
	assign ts_diff  = cmd.timestamp_ms - last_q;
	assign diff     = ts_diff[7:0];
	assign oldest   = byp_q ? byp_data_q : (rd_vld_q ? rd_data_q : 8'd0);
	assign pos_inc  = (pos_q == POS_W'(FILTER_DEPTH - 1)) ? '0 : pos_q + 1'b1;
	assign mem_we   = exec & ring_upd;
	assign rd_addr  = mem_we ? pos_inc : pos_q;

	always_comb begin
		cnt_d    = cnt_q;
		armed_d  = armed_q;
		pins_d   = pins_q;
		act_d    = act_q;
		pend_d   = pend_q;
		tvalid_d = tvalid_q;
		last_d   = last_q;
		pos_d    = pos_q;
		sum_d    = sum_q;
		ignored  = 1'b0;
		ring_upd = 1'b0;
		unique case (cmd.op)
			OP_TICK: begin
				if (tick_cnt == act_q[0]) begin
					pins_d[0] = 1'b1;
					act_d[0]  = pend_q[0];
				end
				if (tick_cnt == act_q[1]) begin
					pins_d[1] = 1'b1;
					act_d[1]  = pend_q[1];
				end
				if (tick_cnt == cfg.rearm_count) begin
					armed_d   = 1'b1;
					pins_d[1] = 1'b0;
				end
				cnt_d = (tick_cnt == cfg.cycle_length) ? '0 : tick_cnt;
			end
			OP_EVENT: begin
				if (!armed_q) begin
					ignored = 1'b1;
				end else begin
					cnt_d     = '0;
					pins_d[0] = 1'b0;
					armed_d   = 1'b0;
					if (tvalid_q) begin
						ring_upd = 1'b1;
						sum_d    = sum_q - SUM_W'(oldest) + SUM_W'(diff);
						pos_d    = pos_inc;
					end
					last_d   = cmd.timestamp_ms;
					tvalid_d = 1'b1;
				end
			end
			OP_SET: begin
				pend_d[cmd.pot_index] = cmd.cmp_value;
			end
			OP_NOP: begin
			end
		endcase
	end

	// period = sum / FILTER_DEPTH, exact over the sum's range
	assign prod = PROD_W'(sum_d) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[pos_q] <= diff;
		end
		rd_data_q  <= ring_mem[rd_addr];
		byp_data_q <= diff;
		if (exec) begin
			out_data_q.charge_pot0      <= pins_d[0];
			out_data_q.charge_pot1      <= pins_d[1];
			out_data_q.period_ms        <= prod[RECIP_SHIFT +: 8];
			out_data_q.comparator_armed <= armed_d;
			out_data_q.event_ignored    <= ignored;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			armed_q     <= 1'b1;
			pins_q      <= '0;
			act_q       <= {INIT_COMPARE, INIT_COMPARE};
			pend_q      <= {INIT_COMPARE, INIT_COMPARE};
			tvalid_q    <= 1'b0;
			last_q      <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				cnt_q    <= cnt_d;
				armed_q  <= armed_d;
				pins_q   <= pins_d;
				act_q    <= act_d;
				pend_q   <= pend_d;
				tvalid_q <= tvalid_d;
				last_q   <= last_d;
				pos_q    <= pos_d;
				sum_q    <= sum_d;
			end
			if (mem_we) begin
				vld_q[pos_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
			byp_q    <= mem_we && (rd_addr == pos_q);
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_event_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		exec && cmd.op == OP_EVENT && armed_q |=> cnt_q == '0 && !armed_q && !pins_q[0])
		else $error("armed comparator event did not restart the cycle");
	a_ignored_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		exec && ignored |-> !armed_q && !ring_upd)
		else $error("comparator event ignored while armed");
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(FILTER_DEPTH * 255))
		else $error("filter sum out of range");

endmodule

FILE: hdl/paddle_pot_charge_timing_core.sv
// Paddle pot charge timing: every transfer on in (tick, comparator event, pot set)
// yields exactly one status transfer on out, in order. One item per clock is
// sustained while out is not stalled. The front decodes each input into a
// two-entry queue at the transfer edge, and the execution stage then updates all
// state and registers the result that is presented on out. The queue lets input
// keep flowing while out is stalled, until both entries are taken. The filter ring
// is a FILTER_DEPTH-entry memory read one entry ahead, and the period is the filter
// sum times a fixed reciprocal. cfg writes take effect on the next item and belong
// to idle periods.
module paddle_pot_charge_timing_core
	import ppct_pkg::*;
#(
	parameter int unsigned FILTER_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_length <= RESET_CYCLE_LENGTH;
			cfg_q.rearm_count  <= RESET_REARM_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CYCLE_LENGTH: begin
					cfg_q.cycle_length <= cfg_data;
				end
				CFG_REARM_COUNT: begin
					cfg_q.rearm_count <= cfg_data;
				end
			endcase
		end
	end

	ppct_front u_front (
		.in_valid (in_valid),
		.in_data  (in_data),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.cmd      (push_cmd)
	);

	ppct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	ppct_back #(
		.FILTER_DEPTH (FILTER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.cmd        (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
